>>> rtl/two_die_net_bbox_hpwl_defines.svh
// assertion helpers shared by the rtl files
// every module that uses them has clk_i and rst_ni
`ifndef TWO_DIE_NET_BBOX_HPWL_DEFINES_SVH
`define TWO_DIE_NET_BBOX_HPWL_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define TDBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define TDBB_NEVER(lbl, expr, msg) \
  `TDBB_ASSERT(lbl, !(expr), msg)

`endif

>>> rtl/tdbb_pkg.sv
package tdbb_pkg;

  // fixed field widths
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned NET_BITS   = COORD_BITS + 3;
  localparam int unsigned TOTAL_BITS = 48;
  localparam int unsigned HALF_BITS  = COORD_BITS + 1;
  // total plus net with one carry bit
  localparam int unsigned SUM_BITS   = ((NET_BITS > TOTAL_BITS) ? NET_BITS : TOTAL_BITS) + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

  // input transaction
  typedef struct packed {
    coord_t pin_x;
    coord_t pin_y;
    logic   on_bottom_die;
    logic   is_terminal;
    logic   last_of_net;
    logic   new_pass;
  } in_item_t;

  // result transaction
  typedef struct packed {
    coord_t                top_min_x;
    coord_t                top_min_y;
    coord_t                top_max_x;
    coord_t                top_max_y;
    coord_t                bot_min_x;
    coord_t                bot_min_y;
    coord_t                bot_max_x;
    coord_t                bot_max_y;
    logic                  top_present;
    logic                  bot_present;
    logic [NET_BITS-1:0]   net_wirelength;
    logic [TOTAL_BITS-1:0] total_wirelength;
  } result_t;

  // classified pin as handed from front to back
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   hit_top;
    logic   hit_bot;
    logic   last;
    logic   clear;
  } pin_op_t;

endpackage

>>> rtl/tdbb_queue.sv
`include "two_die_net_bbox_hpwl_defines.svh"

module tdbb_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  `TDBB_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count above depth")
  `TDBB_ASSERT(a_push_fills, (do_push && !do_pop) |=> !empty_o, "push lost")
  `TDBB_ASSERT(a_last_pop, (do_pop && !do_push && count_q == CNT_W'(1)) |=> empty_o, "pop lost")

endmodule

>>> rtl/tdbb_front.sv
module tdbb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  tdbb_pkg::in_item_t item_i,
  output logic               q_push_o,
  output tdbb_pkg::pin_op_t  q_op_o,
  input  logic               q_full_i
);

  import tdbb_pkg::*;

  logic    valid_q, valid_d;
  pin_op_t op_q, op_d;
  logic    advance;

  // the holding register moves on when empty or when the queue takes it
  assign advance  = !valid_q || !q_full_i;
  assign full_o   = !advance;
  assign q_push_o = valid_q;
  assign q_op_o   = op_q;

  // classify: which boxes the pin widens
  always_comb begin
    op_d.x       = item_i.pin_x;
    op_d.y       = item_i.pin_y;
    op_d.hit_top = item_i.is_terminal || !item_i.on_bottom_die;
    op_d.hit_bot = item_i.is_terminal || item_i.on_bottom_die;
    op_d.last    = item_i.last_of_net;
    op_d.clear   = item_i.new_pass;
    valid_d      = advance ? push_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && push_i) begin
      op_q <= op_d;
    end
  end

endmodule

>>> rtl/tdbb_back.sv
`include "two_die_net_bbox_hpwl_defines.svh"

module tdbb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  tdbb_pkg::pin_op_t q_op_i,
  output logic              q_pop_o,
  output logic              out_push_o,
  output tdbb_pkg::result_t out_res_o,
  input  logic              out_full_i
);

  import tdbb_pkg::*;

  function automatic box_t widen(box_t b, logic seen, coord_t x, coord_t y);
    box_t r;
    r = b;
    if (!seen) begin
      r.min_x = x;
      r.max_x = x;
      r.min_y = y;
      r.max_y = y;
    end else begin
      if ($signed(x) < $signed(b.min_x)) r.min_x = x;
      if ($signed(x) > $signed(b.max_x)) r.max_x = x;
      if ($signed(y) < $signed(b.min_y)) r.min_y = y;
      if ($signed(y) > $signed(b.max_y)) r.max_y = y;
    end
    return r;
  endfunction

  function automatic logic [HALF_BITS-1:0] half_perim(box_t b, logic seen);
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    dx = b.max_x - b.min_x;
    dy = b.max_y - b.min_y;
    return seen ? (HALF_BITS'(dx) + HALF_BITS'(dy)) : '0;
  endfunction

  logic en, take;

  // accumulate stage
  box_t top_q, bot_q, top_new, bot_new;
  logic top_seen_q, bot_seen_q, top_seen_new, bot_seen_new;
  logic pend_clear_q;

  // merged boxes of a finished net
  logic b_valid_q, b_top_seen_q, b_bot_seen_q, b_clear_q;
  box_t b_top_q, b_bot_q;

  // zeroed boxes and half perimeters
  logic                 c_valid_q, c_top_seen_q, c_bot_seen_q, c_clear_q;
  box_t                 c_top_q, c_bot_q;
  logic [HALF_BITS-1:0] c_half_top_q, c_half_bot_q;

  // result register and running total
  logic                  d_valid_q;
  result_t               d_res_q;
  logic [TOTAL_BITS-1:0] total_q, total_d;
  logic [NET_BITS-1:0]   net;
  logic [SUM_BITS-1:0]   sum;

  // whole pipe holds while the finished result cannot leave
  assign en         = !(d_valid_q && out_full_i);
  assign take       = en && !q_empty_i;
  assign q_pop_o    = take;
  assign out_push_o = d_valid_q && !out_full_i;
  assign out_res_o  = d_res_q;

  // box update for the incoming pin
  always_comb begin
    top_new      = q_op_i.hit_top ? widen(top_q, top_seen_q, q_op_i.x, q_op_i.y) : top_q;
    bot_new      = q_op_i.hit_bot ? widen(bot_q, bot_seen_q, q_op_i.x, q_op_i.y) : bot_q;
    top_seen_new = top_seen_q || q_op_i.hit_top;
    bot_seen_new = bot_seen_q || q_op_i.hit_bot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_seen_q   <= 1'b0;
      bot_seen_q   <= 1'b0;
      pend_clear_q <= 1'b0;
    end else if (take) begin
      if (q_op_i.last) begin
        top_seen_q   <= 1'b0;
        bot_seen_q   <= 1'b0;
        pend_clear_q <= 1'b0;
      end else begin
        top_seen_q   <= top_seen_new;
        bot_seen_q   <= bot_seen_new;
        pend_clear_q <= pend_clear_q || q_op_i.clear;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      top_q <= top_new;
      bot_q <= bot_new;
    end
  end

  // net end: hand merged boxes on
  always_ff @(posedge clk_i) begin
    if (take && q_op_i.last) begin
      b_top_q      <= top_new;
      b_bot_q      <= bot_new;
      b_top_seen_q <= top_seen_new;
      b_bot_seen_q <= bot_seen_new;
      b_clear_q    <= pend_clear_q || q_op_i.clear;
    end
  end

  // half perimeters, absent boxes forced to zero
  always_ff @(posedge clk_i) begin
    if (en && b_valid_q) begin
      c_top_q      <= b_top_seen_q ? b_top_q : '0;
      c_bot_q      <= b_bot_seen_q ? b_bot_q : '0;
      c_top_seen_q <= b_top_seen_q;
      c_bot_seen_q <= b_bot_seen_q;
      c_clear_q    <= b_clear_q;
      c_half_top_q <= half_perim(b_top_q, b_top_seen_q);
      c_half_bot_q <= half_perim(b_bot_q, b_bot_seen_q);
    end
  end

  // net sum and saturating total
  always_comb begin
    net     = NET_BITS'(c_half_top_q) + NET_BITS'(c_half_bot_q);
    sum     = SUM_BITS'(c_clear_q ? '0 : total_q) + SUM_BITS'(net);
    total_d = (sum[SUM_BITS-1:TOTAL_BITS] != '0) ? '1 : sum[TOTAL_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (en && c_valid_q) begin
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && c_valid_q) begin
      d_res_q.top_min_x        <= c_top_q.min_x;
      d_res_q.top_min_y        <= c_top_q.min_y;
      d_res_q.top_max_x        <= c_top_q.max_x;
      d_res_q.top_max_y        <= c_top_q.max_y;
      d_res_q.bot_min_x        <= c_bot_q.min_x;
      d_res_q.bot_min_y        <= c_bot_q.min_y;
      d_res_q.bot_max_x        <= c_bot_q.max_x;
      d_res_q.bot_max_y        <= c_bot_q.max_y;
      d_res_q.top_present      <= c_top_seen_q;
      d_res_q.bot_present      <= c_bot_seen_q;
      d_res_q.net_wirelength   <= net;
      d_res_q.total_wirelength <= total_d;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= take && q_op_i.last;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  `TDBB_ASSERT(a_box_present, d_valid_q |-> (d_res_q.top_present || d_res_q.bot_present),
               "result with no present box")
  `TDBB_ASSERT(a_absent_zero, (d_valid_q && !d_res_q.top_present) |->
               ({d_res_q.top_min_x, d_res_q.top_min_y,
                 d_res_q.top_max_x, d_res_q.top_max_y} == '0),
               "absent top box not zero")
  `TDBB_ASSERT(a_total_grows, (en && c_valid_q && !c_clear_q) |=> (total_q >= $past(total_q)),
               "running total shrank without a new pass")

endmodule

>>> rtl/two_die_net_bbox_hpwl.sv
// Two-die net bounding box and half-perimeter wirelength. Pins of a net stream in one
// transaction per cycle while no result is held up by a full output queue, each widening
// the top or bottom die box (a terminal widens both); the transaction flagged last_of_net
// produces one result with both boxes (zero when absent), the net wirelength and a running
// total that saturates at all ones and restarts from the net wirelength when any pin of the
// net carries new_pass. The rate is set by the box compare feeding the accumulate stage. A
// result passes the input register, pin queue, accumulate stage, two result stages and
// output queue before it can be popped; pushing and popping may stall independently.
module two_die_net_bbox_hpwl #(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  tdbb_pkg::in_item_t item_i,
  input  logic               pop_i,
  output logic               empty_o,
  output tdbb_pkg::result_t  result_o
);

  import tdbb_pkg::*;

  pin_op_t front_op, back_op;
  logic    front_push, mid_full, mid_empty, back_pop;
  result_t back_res;
  logic    out_push, out_full;

  // front: register and classify
  tdbb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .item_i   (item_i),
    .q_push_o (front_push),
    .q_op_o   (front_op),
    .q_full_i (mid_full)
  );

  // pin queue between front and back
  tdbb_queue #(
    .WIDTH ($bits(pin_op_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .full_o  (mid_full),
    .data_i  (front_op),
    .pop_i   (back_pop),
    .empty_o (mid_empty),
    .data_o  (back_op)
  );

  // back: boxes, wirelength and total
  tdbb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (mid_empty),
    .q_op_i     (back_op),
    .q_pop_o    (back_pop),
    .out_push_o (out_push),
    .out_res_o  (back_res),
    .out_full_i (out_full)
  );

  // result queue toward the consumer
  tdbb_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .full_o  (out_full),
    .data_i  (back_res),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .data_o  (result_o)
  );

endmodule
